// ===== rtl/core/rbl_pkg.sv =====
// ----------------------------------------------------------------------------
// rbl_pkg
// Shared sizes, register indexes, reset values and the ratio test for the
// red blob locator.
// ----------------------------------------------------------------------------
package rbl_pkg;

  localparam int IMG_WIDTH  = 320;
  localparam int IMG_HEIGHT = 240;

  localparam int ROW_W   = 8;
  localparam int COL_W   = 9;
  localparam int LVL_W   = 8;
  localparam int RCNT_W  = 9;   // red pixels in one row
  localparam int CCNT_W  = 8;   // red pixels in one column
  localparam int TOT_W   = 17;
  localparam int CFG_W   = 17;
  localparam int CFG_IW  = 3;
  localparam int COL_AW  = $clog2(IMG_WIDTH);

  localparam logic [ROW_W:0] ROW_LIMIT = (ROW_W+1)'(IMG_HEIGHT);
  localparam logic [COL_W:0] COL_LIMIT = (COL_W+1)'(IMG_WIDTH);

  localparam logic [RCNT_W-1:0] RCNT_MAX = '1;
  localparam logic [CCNT_W-1:0] CCNT_MAX = '1;
  localparam logic [TOT_W-1:0]  TOT_MAX  = '1;

  localparam logic [RCNT_W-1:0] VIEW_MARGIN = RCNT_W'(10);

  typedef enum logic [CFG_IW-1:0] {
    CFG_LOCATE_MODE = 3'd0,
    CFG_RED_BLUE    = 3'd1,
    CFG_RED_GREEN   = 3'd2,
    CFG_RED_LUM     = 3'd3,
    CFG_SUN_THR     = 3'd4
  } rbl_cfg_e;

  localparam logic             MODE_BBOX     = 1'b0;
  localparam logic             RST_MODE      = 1'b1;
  localparam logic [LVL_W-1:0] RST_RED_BLUE  = 8'd22;
  localparam logic [LVL_W-1:0] RST_RED_GREEN = 8'd22;
  localparam logic [LVL_W-1:0] RST_RED_LUM   = 8'd15;
  localparam logic [TOT_W-1:0] RST_SUN_THR   = 17'd1100;

  // pixel held in the working stage
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             in_range;
    logic             red;
    logic             fend;
  } pix_stage_t;

  // num/den > tenths/10, cross-multiplied so a zero divisor acts like the float ratio
  function automatic logic above_ratio(input logic [LVL_W-1:0] num,
                                       input logic [LVL_W-1:0] den,
                                       input logic [LVL_W-1:0] tenths);
    logic [2*LVL_W-1:0] lhs;
    logic [2*LVL_W-1:0] rhs;
    lhs = ({{LVL_W{1'b0}}, num} << 3) + ({{LVL_W{1'b0}}, num} << 1);
    rhs = {{LVL_W{1'b0}}, tenths} * {{LVL_W{1'b0}}, den};
    return lhs > rhs;
  endfunction

endpackage

// ===== rtl/core/rbl_ram.sv =====
// ----------------------------------------------------------------------------
// rbl_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 320
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/red_blob_locator.sv =====
// ----------------------------------------------------------------------------
// red_blob_locator
// Flags red pixels by ratio thresholds and locates the red blob per frame,
// either as bounding box midpoint or as the row and column with most red.
// ----------------------------------------------------------------------------
//  channel  dir  handshake               payload
//  in       in   in_valid_i/in_ready_o   pix_row, pix_col, levels, frame_end
//  out      out  out_valid_o/out_ready_i blob centre, counts, flags
//  cfg      in   cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// One pixel per clock. Red test runs ahead of the input register; counts and
// trackers update as the beat leaves it, where column counts come back from
// a 320 x 8 RAM read at accept time (last write forwarded).
// A frame_end beat loads the result register as it leaves the input register.
// The input side stalls only when a frame_end beat meets a full, unread
// result register. Reset clears valid and per-frame state, presets the config.
// ----------------------------------------------------------------------------
module red_blob_locator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rbl_pkg::CFG_IW-1:0] cfg_idx_i,
  input  logic [rbl_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [rbl_pkg::ROW_W-1:0]  pix_row_i,
  input  logic [rbl_pkg::COL_W-1:0]  pix_col_i,
  input  logic [rbl_pkg::LVL_W-1:0]  red_level_i,
  input  logic [rbl_pkg::LVL_W-1:0]  green_level_i,
  input  logic [rbl_pkg::LVL_W-1:0]  blue_level_i,
  input  logic [rbl_pkg::LVL_W-1:0]  lum_level_i,
  input  logic                       frame_end_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [rbl_pkg::ROW_W-1:0]  centre_row_o,
  output logic [rbl_pkg::COL_W-1:0]  centre_col_o,
  output logic [rbl_pkg::RCNT_W-1:0] best_row_reds_o,
  output logic [rbl_pkg::CCNT_W-1:0] best_col_reds_o,
  output logic [rbl_pkg::TOT_W-1:0]  red_total_o,
  output logic                       sun_present_o,
  output logic                       in_view_o
);
  import rbl_pkg::*;

  // configuration
  logic             mode_q;
  logic [LVL_W-1:0] rb_thr_q, rg_thr_q, rl_thr_q;
  logic [TOT_W-1:0] sun_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= RST_MODE;
      rb_thr_q  <= RST_RED_BLUE;
      rg_thr_q  <= RST_RED_GREEN;
      rl_thr_q  <= RST_RED_LUM;
      sun_thr_q <= RST_SUN_THR;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LOCATE_MODE: mode_q    <= cfg_wdata_i[0];
        CFG_RED_BLUE:    rb_thr_q  <= cfg_wdata_i[LVL_W-1:0];
        CFG_RED_GREEN:   rg_thr_q  <= cfg_wdata_i[LVL_W-1:0];
        CFG_RED_LUM:     rl_thr_q  <= cfg_wdata_i[LVL_W-1:0];
        CFG_SUN_THR:     sun_thr_q <= cfg_wdata_i[TOT_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  pix_stage_t s1_q, s1_d;
  logic       s1_valid_q;
  logic       s1_fire;
  logic       in_fire;
  logic       out_valid_q;
  logic       out_load;

  assign s1_fire    = s1_valid_q && (!s1_q.fend || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_load   = s1_fire && s1_q.fend;

  always_comb begin
    s1_d.row      = pix_row_i;
    s1_d.col      = pix_col_i;
    s1_d.in_range = ({1'b0, pix_row_i} < ROW_LIMIT) && ({1'b0, pix_col_i} < COL_LIMIT);
    s1_d.red      = above_ratio(red_level_i, blue_level_i, rb_thr_q)
                 && above_ratio(red_level_i, green_level_i, rg_thr_q)
                 && above_ratio(red_level_i, lum_level_i, rl_thr_q);
    s1_d.fend     = frame_end_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= s1_d;
    end
  end

  // column count store, read on accept, written back in the working stage
  logic [CCNT_W-1:0] ram_rdata;
  logic [CCNT_W-1:0] cc_new;
  logic              col_we;
  logic              fwd_valid_q;
  logic [COL_AW-1:0] fwd_col_q;
  logic [CCNT_W-1:0] fwd_val_q;

  assign col_we = s1_fire && s1_q.in_range;

  rbl_ram #(
    .WIDTH (CCNT_W),
    .DEPTH (IMG_WIDTH)
  ) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (col_we),
    .waddr_i (s1_q.col[COL_AW-1:0]),
    .wdata_i (cc_new),
    .re_i    (in_fire && s1_d.in_range),
    .raddr_i (pix_col_i[COL_AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // the read may coincide with the write of the previous beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (col_we) begin
      fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (col_we) begin
      fwd_col_q <= s1_q.col[COL_AW-1:0];
      fwd_val_q <= cc_new;
    end
  end

  // per-frame state
  logic [RCNT_W-1:0] row_count_q, row_count_d;
  logic [ROW_W-1:0]  best_row_q, best_row_d;
  logic [RCNT_W-1:0] best_rcnt_q, best_rcnt_d;
  logic [COL_W-1:0]  best_col_q, best_col_d;
  logic [CCNT_W-1:0] best_ccnt_q, best_ccnt_d;
  logic [TOT_W-1:0]  total_q, total_d;
  logic              seen_q, seen_d;
  logic [ROW_W-1:0]  first_row_q, first_row_d;
  logic [ROW_W-1:0]  last_row_q, last_row_d;
  logic [COL_W-1:0]  least_col_q, least_col_d;
  logic [COL_W-1:0]  most_col_q, most_col_d;

  logic [CCNT_W-1:0] cc_base;
  logic [RCNT_W-1:0] rc_new;

  // result
  logic [ROW_W-1:0]  res_row_d, res_row_q;
  logic [COL_W-1:0]  res_col_d, res_col_q;
  logic [RCNT_W-1:0] res_rreds_d, res_rreds_q;
  logic [CCNT_W-1:0] res_creds_d, res_creds_q;
  logic [TOT_W-1:0]  res_tot_d, res_tot_q;
  logic              res_sun_d, res_sun_q;
  logic              res_view_d, res_view_q;
  logic [ROW_W:0]    row_sum;
  logic [COL_W:0]    col_sum;

  always_comb begin
    row_count_d = row_count_q;
    best_row_d  = best_row_q;
    best_rcnt_d = best_rcnt_q;
    best_col_d  = best_col_q;
    best_ccnt_d = best_ccnt_q;
    total_d     = total_q;
    seen_d      = seen_q;
    first_row_d = first_row_q;
    last_row_d  = last_row_q;
    least_col_d = least_col_q;
    most_col_d  = most_col_q;

    // row 0 starts each column count afresh
    if (s1_q.row == '0) begin
      cc_base = '0;
    end else if (fwd_valid_q && fwd_col_q == s1_q.col[COL_AW-1:0]) begin
      cc_base = fwd_val_q;
    end else begin
      cc_base = ram_rdata;
    end
    rc_new = (s1_q.col == '0) ? '0 : row_count_q;
    cc_new = cc_base;

    if (s1_fire && s1_q.in_range) begin
      if (s1_q.red) begin
        if (rc_new != RCNT_MAX) rc_new = rc_new + 1'b1;
        if (cc_new != CCNT_MAX) cc_new = cc_new + 1'b1;
        if (total_q != TOT_MAX) total_d = total_q + 1'b1;
        if (rc_new > best_rcnt_q || (rc_new == best_rcnt_q && s1_q.row < best_row_q)) begin
          best_rcnt_d = rc_new;
          best_row_d  = s1_q.row;
        end
        if (cc_new > best_ccnt_q || (cc_new == best_ccnt_q && s1_q.col < best_col_q)) begin
          best_ccnt_d = cc_new;
          best_col_d  = s1_q.col;
        end
        seen_d      = 1'b1;
        first_row_d = seen_q ? first_row_q : s1_q.row;
        last_row_d  = s1_q.row;
        least_col_d = (!seen_q || s1_q.col < least_col_q) ? s1_q.col : least_col_q;
        most_col_d  = (!seen_q || s1_q.col > most_col_q) ? s1_q.col : most_col_q;
      end
      row_count_d = rc_new;
    end

    row_sum = {1'b0, first_row_d} + {1'b0, last_row_d};
    col_sum = {1'b0, least_col_d} + {1'b0, most_col_d};
    if (mode_q == MODE_BBOX) begin
      res_row_d   = row_sum[ROW_W:1];
      res_col_d   = col_sum[COL_W:1];
      res_rreds_d = '0;
      res_creds_d = '0;
      res_tot_d   = '0;
    end else begin
      res_row_d   = best_row_d;
      res_col_d   = best_col_d;
      res_rreds_d = best_rcnt_d;
      res_creds_d = best_ccnt_d;
      res_tot_d   = total_d;
    end
    res_sun_d  = res_tot_d > sun_thr_q;
    res_view_d = {1'b0, res_creds_d} > ({1'b0, res_rreds_d[RCNT_W-1:1]} + VIEW_MARGIN);

    if (out_load) begin
      row_count_d = '0;
      best_row_d  = '0;
      best_rcnt_d = '0;
      best_col_d  = '0;
      best_ccnt_d = '0;
      total_d     = '0;
      seen_d      = 1'b0;
      first_row_d = '0;
      last_row_d  = '0;
      least_col_d = '0;
      most_col_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= '0;
      best_row_q  <= '0;
      best_rcnt_q <= '0;
      best_col_q  <= '0;
      best_ccnt_q <= '0;
      total_q     <= '0;
      seen_q      <= 1'b0;
      first_row_q <= '0;
      last_row_q  <= '0;
      least_col_q <= '0;
      most_col_q  <= '0;
    end else begin
      row_count_q <= row_count_d;
      best_row_q  <= best_row_d;
      best_rcnt_q <= best_rcnt_d;
      best_col_q  <= best_col_d;
      best_ccnt_q <= best_ccnt_d;
      total_q     <= total_d;
      seen_q      <= seen_d;
      first_row_q <= first_row_d;
      last_row_q  <= last_row_d;
      least_col_q <= least_col_d;
      most_col_q  <= most_col_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_row_q   <= res_row_d;
      res_col_q   <= res_col_d;
      res_rreds_q <= res_rreds_d;
      res_creds_q <= res_creds_d;
      res_tot_q   <= res_tot_d;
      res_sun_q   <= res_sun_d;
      res_view_q  <= res_view_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign centre_row_o    = res_row_q;
  assign centre_col_o    = res_col_q;
  assign best_row_reds_o = res_rreds_q;
  assign best_col_reds_o = res_creds_q;
  assign red_total_o     = res_tot_q;
  assign sun_present_o   = res_sun_q;
  assign in_view_o       = res_view_q;

  // checks
  a_stall_only_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && s1_q.fend && out_valid_q)
    else $error("input stalled without a pending frame end");

  a_frame_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> total_q == '0 && !seen_q && best_rcnt_q == '0)
    else $error("per-frame state not cleared after frame end");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q)
    else $error("frame end beat produced no result");

  a_seen_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seen_q |-> total_q == '0)
    else $error("red total counted without any red pixel");

endmodule

// ===== verif/red_blob_locator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// red_blob_locator_tb
// Streams raster frames, broken frames and stray pixels into the locator under
// random sender bursts and receiver stalls. A scoreboard mirrors the red test,
// the row, column and box trackers and the column count store, then checks
// every result beat field by field. Thresholds and mode change between phases.
// ----------------------------------------------------------------------------
module red_blob_locator_tb;
  import rbl_pkg::*;

  localparam int  CYCLE_LIMIT  = 600000;
  localparam int  RANDOM_ITEMS = 1400;
  localparam int  DRAIN_CYCLES = 6;
  localparam int  STREAK_LEN   = 520;   // enough to saturate a row and a column count
  localparam logic MODE_MOST   = ~MODE_BBOX;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [LVL_W-1:0] red_lvl;
    logic [LVL_W-1:0] green_lvl;
    logic [LVL_W-1:0] blue_lvl;
    logic [LVL_W-1:0] lum_lvl;
    logic             fend;
  } pixel_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [RCNT_W-1:0] row_reds;
    logic [CCNT_W-1:0] col_reds;
    logic [TOT_W-1:0]  total;
    logic              sun;
    logic              view;
  } centre_t;

  class blob_centre_board;
    logic    mode;
    int      blue_tenths;
    int      green_tenths;
    int      lum_tenths;
    int      sun_level;
    int      col_reds[IMG_WIDTH];
    int      row_reds;
    int      top_row;
    int      top_row_reds;
    int      top_col;
    int      top_col_reds;
    int      red_sum;
    bit      seen_red;
    int      first_row;
    int      last_row;
    int      min_col;
    int      max_col;
    centre_t expected_centres[$];
    int      errors;

    function new();
      mode         = RST_MODE;
      blue_tenths  = RST_RED_BLUE;
      green_tenths = RST_RED_GREEN;
      lum_tenths   = RST_RED_LUM;
      sun_level    = RST_SUN_THR;
      foreach (col_reds[i]) col_reds[i] = 0;
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      row_reds     = 0;
      top_row      = 0;
      top_row_reds = 0;
      top_col      = 0;
      top_col_reds = 0;
      red_sum      = 0;
      seen_red     = 1'b0;
      first_row    = 0;
      last_row     = 0;
      min_col      = 0;
      max_col      = 0;
    endfunction

    function void set_reg(rbl_cfg_e idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_LOCATE_MODE: mode = val[0];
        CFG_RED_BLUE:    blue_tenths = val[LVL_W-1:0];
        CFG_RED_GREEN:   green_tenths = val[LVL_W-1:0];
        CFG_RED_LUM:     lum_tenths = val[LVL_W-1:0];
        CFG_SUN_THR:     sun_level = val[TOT_W-1:0];
        default: ;
      endcase
    endfunction

    // cross-multiplied ratio: a zero divisor passes for any nonzero red
    function bit ratio_over(int num, int den, int tenths);
      return num * 10 > tenths * den;
    endfunction

    function void take_pixel(pixel_t p);
      bit      is_red;
      int      cc;
      centre_t c;
      if (p.row < IMG_HEIGHT && p.col < IMG_WIDTH) begin
        is_red = ratio_over(p.red_lvl, p.blue_lvl, blue_tenths) &&
                 ratio_over(p.red_lvl, p.green_lvl, green_tenths) &&
                 ratio_over(p.red_lvl, p.lum_lvl, lum_tenths);
        if (p.col == 0) row_reds = 0;
        cc = (p.row == 0) ? 0 : col_reds[p.col];
        if (is_red) begin
          if (row_reds < RCNT_MAX) row_reds++;
          if (cc < CCNT_MAX) cc++;
          if (red_sum < TOT_MAX) red_sum++;
          if (row_reds > top_row_reds || (row_reds == top_row_reds && p.row < top_row)) begin
            top_row_reds = row_reds;
            top_row      = p.row;
          end
          if (cc > top_col_reds || (cc == top_col_reds && p.col < top_col)) begin
            top_col_reds = cc;
            top_col      = p.col;
          end
          if (!seen_red) begin
            first_row = p.row;
            min_col   = p.col;
            max_col   = p.col;
            seen_red  = 1'b1;
          end
          last_row = p.row;
          if (p.col < min_col) min_col = p.col;
          if (p.col > max_col) max_col = p.col;
        end
        col_reds[p.col] = cc;
      end
      if (p.fend) begin
        c = '0;
        if (mode == MODE_BBOX) begin
          c.row = ROW_W'((first_row + last_row) / 2);
          c.col = COL_W'((min_col + max_col) / 2);
        end else begin
          c.row      = ROW_W'(top_row);
          c.col      = COL_W'(top_col);
          c.row_reds = RCNT_W'(top_row_reds);
          c.col_reds = CCNT_W'(top_col_reds);
          c.total    = TOT_W'(red_sum);
        end
        c.sun  = c.total > sun_level;
        c.view = c.col_reds > c.row_reds / 2 + 10;
        expected_centres.push_back(c);
        clear_frame();
      end
    endfunction

    function void cmp(string name, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void match_result(centre_t got);
      centre_t want;
      if (expected_centres.size() == 0) begin
        $error("result beat with no frame end pending");
        errors++;
        return;
      end
      want = expected_centres.pop_front();
      cmp("centre_row", want.row, got.row);
      cmp("centre_col", want.col, got.col);
      cmp("best_row_reds", want.row_reds, got.row_reds);
      cmp("best_col_reds", want.col_reds, got.col_reds);
      cmp("red_total", want.total, got.total);
      cmp("sun_present", want.sun, got.sun);
      cmp("in_view", want.view, got.view);
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CFG_IW-1:0]  cfg_idx_i;
  logic [CFG_W-1:0]   cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [ROW_W-1:0]   pix_row_i;
  logic [COL_W-1:0]   pix_col_i;
  logic [LVL_W-1:0]   red_level_i;
  logic [LVL_W-1:0]   green_level_i;
  logic [LVL_W-1:0]   blue_level_i;
  logic [LVL_W-1:0]   lum_level_i;
  logic               frame_end_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [ROW_W-1:0]   centre_row_o;
  logic [COL_W-1:0]   centre_col_o;
  logic [RCNT_W-1:0]  best_row_reds_o;
  logic [CCNT_W-1:0]  best_col_reds_o;
  logic [TOT_W-1:0]   red_total_o;
  logic               sun_present_o;
  logic               in_view_o;

  blob_centre_board locator_model = new();

  bit          col_written[IMG_WIDTH];
  int          burst_left;
  int          gap_max;
  logic [15:0] stall_bits = '1;
  int          stall_pos;
  int          sent;
  int          cycles;

  red_blob_locator dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= stall_bits[stall_pos];
    stall_pos = (stall_pos + 1) % 16;
  end

  always @(posedge clk_i) begin
    pixel_t  p;
    centre_t c;
    if (rst_ni) begin
      if (cfg_we_i) locator_model.set_reg(rbl_cfg_e'(cfg_idx_i), cfg_wdata_i);
      if (in_valid_i && in_ready_o) begin
        p = '{pix_row_i, pix_col_i, red_level_i, green_level_i, blue_level_i,
              lum_level_i, frame_end_i};
        locator_model.take_pixel(p);
      end
      if (out_valid_o && out_ready_i) begin
        c = '{centre_row_o, centre_col_o, best_row_reds_o, best_col_reds_o,
              red_total_o, sun_present_o, in_view_o};
        locator_model.match_result(c);
      end
    end
  end

  // never read a column count before some row 0 pixel has written it
  task automatic drive_pixel(pixel_t p);
    int gap;
    if (p.row < IMG_HEIGHT && p.col < IMG_WIDTH) begin
      if (p.row != 0 && !col_written[p.col]) p.row = '0;
      if (p.row == 0) col_written[p.col] = 1'b1;
    end
    if (burst_left == 0) begin
      gap        = $urandom_range(0, gap_max);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    pix_row_i     <= p.row;
    pix_col_i     <= p.col;
    red_level_i   <= p.red_lvl;
    green_level_i <= p.green_lvl;
    blue_level_i  <= p.blue_lvl;
    lum_level_i   <= p.lum_lvl;
    frame_end_i   <= p.fend;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    sent++;
  endtask

  task automatic send_levels(int row, int col, int r, int g, int b, int l, bit fend);
    drive_pixel('{ROW_W'(row), COL_W'(col), LVL_W'(r), LVL_W'(g), LVL_W'(b),
                  LVL_W'(l), fend});
  endtask

  function automatic int low_level(int r);
    if ($urandom_range(0, 7) == 0) return 0;
    return $urandom_range(0, r / 3);
  endfunction

  // about half the pixels lean red, the rest are arbitrary colors
  function automatic pixel_t make_pixel(int row, int col, bit fend);
    pixel_t p;
    int     r;
    p.row  = ROW_W'(row);
    p.col  = COL_W'(col);
    p.fend = fend;
    if ($urandom_range(0, 1)) begin
      r = $urandom_range(100, 255);
      p.green_lvl = LVL_W'(low_level(r));
      p.blue_lvl  = LVL_W'(low_level(r));
      p.lum_lvl   = LVL_W'(low_level(r));
    end else begin
      r = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(0, 255);
      p.green_lvl = LVL_W'($urandom_range(0, 255));
      p.blue_lvl  = LVL_W'($urandom_range(0, 255));
      p.lum_lvl   = LVL_W'($urandom_range(0, 255));
    end
    p.red_lvl = LVL_W'(r);
    return p;
  endfunction

  task automatic send_frame(int r0, int c0, int h, int w, int stop_at, bit with_end);
    int idx;
    for (int rr = 0; rr < h; rr++) begin
      for (int cc = 0; cc < w; cc++) begin
        idx = rr * w + cc;
        if (idx > stop_at) return;
        drive_pixel(make_pixel(r0 + rr, c0 + cc, with_end && idx == stop_at));
      end
    end
  endtask

  task automatic send_noise(int n);
    repeat (n) begin
      drive_pixel(make_pixel($urandom_range(0, 255), $urandom_range(0, 511),
                             $urandom_range(0, 7) == 0));
    end
  endtask

  task automatic send_random_frame();
    int k;
    int h;
    int w;
    int r0;
    int c0;
    k = $urandom_range(0, 29);
    if (k == 0) begin
      w = IMG_WIDTH;
      h = $urandom_range(1, 2);
    end else if (k == 1) begin
      w = 1;
      h = IMG_HEIGHT;
    end else begin
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 8);
    end
    r0 = ($urandom_range(0, 3) == 0) ? $urandom_range(0, IMG_HEIGHT - h) : 0;
    c0 = ($urandom_range(0, 3) == 0) ? $urandom_range(0, IMG_WIDTH - w) : 0;
    if ($urandom_range(0, 7) == 0)
      send_frame(r0, c0, h, w, $urandom_range(0, h * w - 1), $urandom_range(0, 1));
    else
      send_frame(r0, c0, h, w, h * w - 1, 1'b1);
  endtask

  task automatic write_reg(rbl_cfg_e idx, int val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= CFG_W'(val);
    @(negedge clk_i);
  endtask

  task automatic apply_config(logic mode, int rb, int rg, int rl, int sun);
    write_reg(CFG_LOCATE_MODE, mode);
    write_reg(CFG_RED_BLUE, rb);
    write_reg(CFG_RED_GREEN, rg);
    write_reg(CFG_RED_LUM, rl);
    write_reg(CFG_SUN_THR, sun);
    cfg_we_i <= 1'b0;
  endtask

  // hold the sender until every result is back and the pipe is empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (locator_model.expected_centres.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic int pick_tenths();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 255;
      default: return $urandom_range(5, 40);
    endcase
  endfunction

  function automatic int pick_sun();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return IMG_WIDTH * IMG_HEIGHT;
      2: return $urandom_range(0, 60);
      default: return $urandom_range(0, IMG_WIDTH * IMG_HEIGHT);
    endcase
  endfunction

  initial begin
    int target;
    int phase;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    pix_row_i     = '0;
    pix_col_i     = '0;
    red_level_i   = '0;
    green_level_i = '0;
    blue_level_i  = '0;
    lum_level_i   = '0;
    frame_end_i   = 1'b0;
    gap_max       = 3;
    burst_left    = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset thresholds: zero divisors, exact ratio ties, range edges
    send_levels(0, 0, 255, 0, 0, 0, 1'b0);
    send_levels(0, 1, 0, 0, 0, 0, 1'b0);
    send_levels(0, 319, 200, 10, 10, 10, 1'b0);
    send_levels(1, 0, 100, 45, 45, 66, 1'b0);
    send_levels(1, 1, 99, 45, 45, 10, 1'b0);
    send_levels(1, 319, 255, 255, 255, 255, 1'b0);
    send_levels(239, 319, 255, 1, 1, 1, 1'b0);
    send_levels(240, 0, 255, 0, 0, 0, 1'b0);
    send_levels(0, 320, 255, 0, 0, 0, 1'b0);
    send_levels(255, 511, 255, 0, 0, 0, 1'b1);   // off-image pixel still closes the frame
    send_levels(0, 2, 10, 200, 200, 200, 1'b1);  // frame without red
    settle();
    apply_config(MODE_BBOX, 0, 0, 0, 0);
    send_levels(0, 5, 1, 255, 255, 255, 1'b0);
    send_levels(0, 7, 0, 0, 0, 0, 1'b0);
    send_levels(2, 0, 1, 0, 0, 0, 1'b0);
    send_levels(1, 319, 128, 0, 0, 0, 1'b1);
    send_levels(0, 3, 0, 255, 0, 0, 1'b1);
    settle();
    apply_config(MODE_MOST, 255, 255, 255, IMG_WIDTH * IMG_HEIGHT);
    send_levels(0, 4, 255, 0, 0, 0, 1'b0);
    send_levels(0, 6, 255, 10, 10, 10, 1'b0);
    send_levels(1, 4, 255, 9, 9, 9, 1'b1);
    settle();
    apply_config(MODE_MOST, 22, 22, 15, 0);
    send_levels(0, 8, 200, 10, 10, 10, 1'b1);

    target = sent + RANDOM_ITEMS;
    phase  = 0;
    while (sent < target) begin
      settle();
      apply_config($urandom_range(0, 1) ? MODE_MOST : MODE_BBOX, pick_tenths(),
                   pick_tenths(), pick_tenths(), pick_sun());
      stall_bits <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h1);
      case ($urandom_range(0, 2))
        0: gap_max = 0;
        1: gap_max = 3;
        default: gap_max = 12;
      endcase
      if (phase == 2) begin
        // one long red run in a single column, never touching column 0
        send_levels(0, 1, 0, 0, 0, 0, 1'b0);
        for (int i = 0; i < STREAK_LEN; i++)
          send_levels($urandom_range(1, IMG_HEIGHT - 1), 1, 255, 0, 0, 0,
                      i == STREAK_LEN - 1);
      end
      repeat ($urandom_range(2, 6)) begin
        if ($urandom_range(0, 4) == 0) send_noise($urandom_range(1, 20));
        else send_random_frame();
      end
      phase++;
    end
    settle();

    if (locator_model.errors == 0 && locator_model.expected_centres.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
